/* src/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg
// shared widths, types and constants for the 3x3 matrix inverse
// ----------------------------------------------------------------------------
package m3i_pkg;
	localparam int DW     = 32;            // element width
	localparam int FB     = 16;            // fraction bits
	localparam int NL     = 9;             // elements per matrix
	localparam int PW     = 2 * DW;        // cofactor width
	localparam int DETW   = 3 * DW + 1;    // determinant width
	localparam int NUMW   = PW + 2 * FB + 1; // shifted dividend width
	localparam int QB     = DW + 2;        // quotient bits incl. round bit
	localparam int R0W    = NUMW - QB;     // leading dividend part
	localparam int THRW   = 31;            // threshold register width
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef logic signed [DW-1:0]   data_t;
	typedef logic signed [PW-1:0]   cof_t;
	typedef logic signed [DETW-1:0] det_t;
	typedef logic [DETW-1:0]        mag_t;
	typedef logic [THRW-1:0]        thr_t;

	typedef struct packed {
		logic [NL-1:0][PW-1:0] adj;
		mag_t                  absd;
		logic                  det_neg;
		logic                  singular;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	localparam data_t ONE  = data_t'(1) << FB;
	localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};

	// cofactor k = a[p]*a[q] - a[s]*a[t]
	localparam int COF_IDX [NL][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};
endpackage

/* src/m3i_front.sv */
// ----------------------------------------------------------------------------
// m3i_front
// cofactors, determinant and singular test, five stages
// ----------------------------------------------------------------------------
module m3i_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  m3i_pkg::data_t     a_in [m3i_pkg::NL],
	input  m3i_pkg::thr_t      thr,
	input  logic               q_full,
	output logic               push_valid,
	output m3i_pkg::entry_t    push_entry
);
	import m3i_pkg::*;

	logic  adv;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	data_t a_s1 [NL];
	data_t a_s2 [3];
	data_t a_s3 [3];
	cof_t  prod_s2 [2*NL];
	cof_t  adj_s3 [NL];
	cof_t  adj_s4 [NL];
	cof_t  adj_s5 [NL];
	logic signed [PW:0]   pl_s4 [3];
	logic signed [PW-1:0] ph_s4 [3];
	det_t  det_s5;
	mag_t  absd;
	mag_t  thr_w;

	assign adv        = !v_s5 || !q_full;
	assign in_stall   = !adv;
	assign push_valid = v_s5 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NL; k++) begin
				a_s1[k]          <= a_in[k];
				prod_s2[2*k]     <= cof_t'(a_s1[COF_IDX[k][0]]) * cof_t'(a_s1[COF_IDX[k][1]]);
				prod_s2[2*k+1]   <= cof_t'(a_s1[COF_IDX[k][2]]) * cof_t'(a_s1[COF_IDX[k][3]]);
				adj_s3[k]        <= prod_s2[2*k] - prod_s2[2*k+1];
				adj_s4[k]        <= adj_s3[k];
				adj_s5[k]        <= adj_s4[k];
			end
			for (int j = 0; j < 3; j++) begin
				a_s2[j]  <= a_s1[j];
				a_s3[j]  <= a_s2[j];
				// first-row expansion, cofactor split into low and high halves
				pl_s4[j] <= (PW+1)'(a_s3[j]) * $signed({1'b0, adj_s3[3*j][DW-1:0]});
				ph_s4[j] <= PW'(a_s3[j]) * PW'($signed(adj_s3[3*j][PW-1:DW]));
			end
			det_s5 <= (det_t'(ph_s4[0]) <<< DW) + det_t'(pl_s4[0])
			        + (det_t'(ph_s4[1]) <<< DW) + det_t'(pl_s4[1])
			        + (det_t'(ph_s4[2]) <<< DW) + det_t'(pl_s4[2]);
		end
	end

	always_comb begin
		absd  = det_s5[DETW-1] ? mag_t'(-det_s5) : mag_t'(det_s5);
		thr_w = mag_t'(thr) << (2 * FB);
		for (int k = 0; k < NL; k++) begin
			push_entry.adj[k] = adj_s5[k];
		end
		push_entry.absd     = absd;
		push_entry.det_neg  = det_s5[DETW-1];
		push_entry.singular = (absd == '0) || (absd < thr_w);
	end
endmodule

/* src/m3i_fifo.sv */
// ----------------------------------------------------------------------------
// m3i_fifo
// short queue between front and back
// ----------------------------------------------------------------------------
module m3i_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  m3i_pkg::entry_t  wr_entry,
	input  logic             pop,
	output m3i_pkg::entry_t  rd_entry,
	output m3i_pkg::qstat_t  stat
);
	import m3i_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign rd_entry   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end
endmodule

/* src/m3i_back.sv */
// ----------------------------------------------------------------------------
// m3i_back
// nine pipelined restoring dividers, rounding, saturation, output register
// ----------------------------------------------------------------------------
module m3i_back (
	input  logic             clk,
	input  logic             arst_n,
	input  m3i_pkg::entry_t  rd_entry,
	input  m3i_pkg::qstat_t  q_stat,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output m3i_pkg::data_t   b [m3i_pkg::NL],
	output logic             singular
);
	import m3i_pkg::*;

	localparam logic [QB-1:0] QLIM = {{(QB-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

	logic adv;
	logic out_valid_q;
	logic singular_q;
	data_t b_q [NL];

	// per stage, per lane
	logic           vld_s  [QB+1];
	logic           sing_s [QB+1];
	mag_t           absd_s [QB+1];
	mag_t           rem_s  [QB+1][NL];
	logic [QB-1:0]  quo_s  [QB+1][NL];
	logic [QB-1:0]  low_s  [QB+1][NL];
	logic           sat_s  [QB+1][NL];
	logic           neg_s  [QB+1][NL];

	mag_t           rem_n  [QB][NL];
	logic           bit_n  [QB][NL];

	mag_t           r0     [NL];
	logic [QB-1:0]  low0   [NL];
	logic           sat0   [NL];
	logic           neg0   [NL];

	data_t          res    [NL];

	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign singular  = singular_q;

	// load: magnitude, leading dividend part, early overflow check
	always_comb begin
		logic signed [PW-1:0] adj_l;
		logic [PW-1:0]        mag_l;
		logic [NUMW-1:0]      num;
		for (int l = 0; l < NL; l++) begin
			adj_l   = $signed(rd_entry.adj[l]);
			mag_l   = adj_l[PW-1] ? PW'(-adj_l) : PW'(adj_l);
			num     = {mag_l, {(2*FB+1){1'b0}}};
			r0[l]   = mag_t'(num[NUMW-1:QB]);
			low0[l] = num[QB-1:0];
			sat0[l] = (mag_t'(num[NUMW-1:QB]) >= rd_entry.absd);
			neg0[l] = adj_l[PW-1] ^ rd_entry.det_neg;
		end
	end

	// one quotient bit per stage
	always_comb begin
		logic [DETW:0] r2;
		for (int st = 0; st < QB; st++) begin
			for (int l = 0; l < NL; l++) begin
				r2 = {rem_s[st][l], low_s[st][l][QB-1]};
				if (r2 >= {1'b0, absd_s[st]}) begin
					rem_n[st][l] = mag_t'(r2 - {1'b0, absd_s[st]});
					bit_n[st][l] = 1'b1;
				end else begin
					rem_n[st][l] = r2[DETW-1:0];
					bit_n[st][l] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st <= QB; st++) begin
				vld_s[st] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= pop;
			for (int st = 0; st < QB; st++) begin
				vld_s[st+1] <= vld_s[st];
			end
			out_valid_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_s[0] <= rd_entry.singular;
			absd_s[0] <= rd_entry.absd;
			for (int l = 0; l < NL; l++) begin
				rem_s[0][l] <= r0[l];
				quo_s[0][l] <= '0;
				low_s[0][l] <= low0[l];
				sat_s[0][l] <= sat0[l];
				neg_s[0][l] <= neg0[l];
			end
			for (int st = 0; st < QB; st++) begin
				sing_s[st+1] <= sing_s[st];
				absd_s[st+1] <= absd_s[st];
				for (int l = 0; l < NL; l++) begin
					rem_s[st+1][l] <= rem_n[st][l];
					quo_s[st+1][l] <= {quo_s[st][l][QB-2:0], bit_n[st][l]};
					low_s[st+1][l] <= low_s[st][l] << 1;
					sat_s[st+1][l] <= sat_s[st][l];
					neg_s[st+1][l] <= neg_s[st][l];
				end
			end
			singular_q <= sing_s[QB];
			for (int l = 0; l < NL; l++) begin
				b_q[l] <= res[l];
			end
		end
	end

	// round half away from zero, saturate, identity on singular
	always_comb begin
		logic [QB:0]   qr;
		logic [QB-1:0] q;
		logic          ovf;
		for (int l = 0; l < NL; l++) begin
			qr  = {1'b0, quo_s[QB][l]} + 1'b1;
			q   = qr[QB:1];
			ovf = sat_s[QB][l] || (neg_s[QB][l] ? (q > QLIM) : (q >= QLIM));
			if (sing_s[QB]) begin
				res[l] = (l % 4 == 0) ? ONE : '0;
			end else if (ovf) begin
				res[l] = neg_s[QB][l] ? DMIN : DMAX;
			end else begin
				res[l] = neg_s[QB][l] ? data_t'(-q[DW-1:0]) : data_t'(q[DW-1:0]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			b[l] = b_q[l];
		end
	end
endmodule

/* src/matrix3_inverse_top.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse_top
// 3x3 fixed-point matrix inverse through the adjugate and the determinant
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with the nine elements a00..a22,
//   row-major, signed q16.16; a transfer happens when in_valid is high and
//   in_stall is low
//   output channel: out_valid / out_stall with b00..b22 and singular
//   config channel: cfg_valid / cfg_ready with cfg_data, the singular
//   threshold; cfg_ready is always high, so every write is a transfer
//   throughput: one matrix per cycle without stall, set by the front
//   multiplier pipeline and the nine dividers, one quotient bit per stage
//   pipeline: 5 front stages, the queue, 35 divider stages and the
//   output register
//   singular matrices (|det| below threshold, or det zero) return the
//   identity with singular high
//   out_stall freezes the back pipeline; the 4-entry queue then absorbs the
//   front until it fills, after which in_stall rises
//   reset clears all valid bits and the queue, threshold returns to 1
// ----------------------------------------------------------------------------
module matrix3_inverse_top (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  m3i_pkg::data_t        a00, a01, a02,
	input  m3i_pkg::data_t        a10, a11, a12,
	input  m3i_pkg::data_t        a20, a21, a22,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output m3i_pkg::data_t        b00, b01, b02,
	output m3i_pkg::data_t        b10, b11, b12,
	output m3i_pkg::data_t        b20, b21, b22,
	output logic                  singular,
	// config channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  m3i_pkg::thr_t         cfg_data
);
	import m3i_pkg::*;

	thr_t   thr_q;
	data_t  a_vec [NL];
	data_t  b_vec [NL];
	logic   push_valid;
	entry_t push_entry;
	entry_t rd_entry;
	qstat_t q_stat;
	logic   pop;

	// threshold register, written on a config transfer
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= thr_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	assign a_vec[0] = a00;
	assign a_vec[1] = a01;
	assign a_vec[2] = a02;
	assign a_vec[3] = a10;
	assign a_vec[4] = a11;
	assign a_vec[5] = a12;
	assign a_vec[6] = a20;
	assign a_vec[7] = a21;
	assign a_vec[8] = a22;

	// front: cofactors, determinant, singular classification
	m3i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_in       (a_vec),
		.thr        (thr_q),
		.q_full     (q_stat.full),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// decoupling queue
	m3i_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (q_stat)
	);

	// back: division, rounding, saturation, output register
	m3i_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_entry  (rd_entry),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.b         (b_vec),
		.singular  (singular)
	);

	assign b00 = b_vec[0];
	assign b01 = b_vec[1];
	assign b02 = b_vec[2];
	assign b10 = b_vec[3];
	assign b11 = b_vec[4];
	assign b12 = b_vec[5];
	assign b20 = b_vec[6];
	assign b21 = b_vec[7];
	assign b22 = b_vec[8];

	// singular result must be the identity
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> b00 == ONE && b11 == ONE && b22 == ONE &&
		b01 == '0 && b02 == '0 && b10 == '0 && b12 == '0 && b20 == '0 && b21 == '0)
		else $error("singular result is not the identity");

	// queue can never look both full and empty
	a_qstat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

	// a pop never happens on an empty queue, a push never on a full one
	a_qflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty) && !(push_valid && q_stat.full))
		else $error("queue overflow or underflow");
endmodule
